@@ rtl/lj_pair_force_kernel_macros.svh @@
// assertion macros for the lennard-jones pair force kernel
// used by lj_pair_force_kernel, expects clk_i and rst_ni in scope
`ifndef LJ_PAIR_FORCE_KERNEL_MACROS_SVH
`define LJ_PAIR_FORCE_KERNEL_MACROS_SVH

// same-cycle implication
`define LJPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lj_pair_force_kernel assertion failed");

// next-cycle implication
`define LJPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lj_pair_force_kernel assertion failed");

`endif

@@ rtl/ljpf_pkg.sv @@
// shared types and constants of the lennard-jones pair force kernel
// no dependencies
package ljpf_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned QDIV_LAT   = WORD_W + 1;
  localparam int unsigned QMUL_LAT   = 3;
  localparam int unsigned IN_DATA_W  = 248;
  localparam int unsigned OUT_DATA_W = 192;

  typedef logic [WORD_W-1:0] qword_t;

  localparam qword_t LIM      = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam qword_t LIM_DIV4 = LIM / 4;
  localparam qword_t LIM_DIV6 = LIM / 6;
  localparam qword_t LIM_DIV12 = LIM / 12;
  localparam qword_t QONE_SQ  = 64'd1 << (2 * FRAC_BITS);
  localparam qword_t POS_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam qword_t NEG_MAX  = 64'h0000_0000_8000_0000;

  localparam logic [30:0] CUTOFF_RESET = 31'd163840;

  typedef enum logic [2:0] {
    ST_APPLIED    = 3'd0,
    ST_BEYOND     = 3'd1,
    ST_ORDER_SKIP = 3'd2,
    ST_ZERO_DIST  = 3'd3,
    ST_SATURATED  = 3'd4
  } status_e;

  // per-item sideband that travels beside the arithmetic
  typedef struct packed {
    logic             valid;
    logic             skip;
    status_e          code;
    logic [2:0][31:0] mag;
    logic [2:0]       dneg;
    logic [30:0]      eps;
    logic [30:0]      ims;
    logic [30:0]      imp;
    logic             ghost;
  } sb_t;

  typedef struct packed {
    status_e          status;
    logic [5:0][31:0] accel;
  } out_t;

endpackage

@@ rtl/ljpf_delay.sv @@
// enabled delay line of fixed depth, cleared by reset
// no dependencies
module ljpf_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < DEPTH; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int unsigned i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

@@ rtl/ljpf_qmul.sv @@
// pipelined fixed-point multiply (a*b)>>FRAC_BITS with clamp, three stages
// depends on ljpf_pkg
module ljpf_qmul (
  input  logic            clk_i,
  input  logic            en_i,
  input  ljpf_pkg::qword_t a_i,
  input  ljpf_pkg::qword_t b_i,
  input  logic            sat_i,
  output ljpf_pkg::qword_t p_o,
  output logic            sat_o
);

  logic [63:0]      pp00_d, pp01_d, pp10_d, pp11_d;
  logic [63:0]      pp00_q, pp01_q, pp10_q, pp11_q;
  logic             sat1_q, sat2_q, sat3_q;
  logic [127:0]     prod_d, prod_q;
  ljpf_pkg::qword_t shifted, p_q;
  logic             over;

  assign pp00_d = a_i[31:0] * b_i[31:0];
  assign pp01_d = a_i[31:0] * b_i[63:32];
  assign pp10_d = a_i[63:32] * b_i[31:0];
  assign pp11_d = a_i[63:32] * b_i[63:32];

  assign prod_d = {64'd0, pp00_q} + ({64'd0, pp01_q} << 32) + ({64'd0, pp10_q} << 32)
                + {pp11_q, 64'd0};

  assign shifted = prod_q[ljpf_pkg::FRAC_BITS +: ljpf_pkg::WORD_W];
  assign over    = (prod_q[127:ljpf_pkg::FRAC_BITS+ljpf_pkg::WORD_W] != '0)
                || (shifted > ljpf_pkg::LIM);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= pp00_d;
      pp01_q <= pp01_d;
      pp10_q <= pp10_d;
      pp11_q <= pp11_d;
      sat1_q <= sat_i;
      prod_q <= prod_d;
      sat2_q <= sat1_q;
      p_q    <= over ? ljpf_pkg::LIM : shifted;
      sat3_q <= sat2_q | over;
    end
  end

  assign p_o   = p_q;
  assign sat_o = sat3_q;

endmodule

@@ rtl/ljpf_qdiv.sv @@
// pipelined restoring divider (a<<FRAC_BITS)/b, one quotient bit per step
// depends on ljpf_pkg
module ljpf_qdiv (
  input  logic            clk_i,
  input  logic            en_i,
  input  ljpf_pkg::qword_t a_i,
  input  ljpf_pkg::qword_t b_i,
  output ljpf_pkg::qword_t q_o,
  output logic            sat_o
);

  localparam int unsigned STEPS = ljpf_pkg::WORD_W;
  localparam int unsigned W     = ljpf_pkg::WORD_W;

  ljpf_pkg::qword_t rem_q [STEPS+1];
  ljpf_pkg::qword_t lo_q  [STEPS+1];
  ljpf_pkg::qword_t quo_q [STEPS+1];
  ljpf_pkg::qword_t div_q [STEPS+1];
  logic             sat_q [STEPS+1];
  ljpf_pkg::qword_t hi;

  assign hi = a_i >> (W - ljpf_pkg::FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi;
      lo_q[0]  <= a_i << ljpf_pkg::FRAC_BITS;
      quo_q[0] <= '0;
      div_q[0] <= b_i;
      sat_q[0] <= (b_i == '0) || (hi >= b_i);
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    ljpf_pkg::qword_t rem_sh, rem_nx;
    logic             ge;

    always_comb begin
      rem_sh = {rem_q[s][W-2:0], lo_q[s][W-1]};
      ge     = rem_q[s][W-1] | (rem_sh >= div_q[s]);
      rem_nx = ge ? rem_sh - div_q[s] : rem_sh;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_nx;
        lo_q[s+1]  <= {lo_q[s][W-2:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][W-2:0], ge};
        div_q[s+1] <= div_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  assign sat_o = sat_q[STEPS] || (quo_q[STEPS] > ljpf_pkg::LIM);
  assign q_o   = sat_o ? ljpf_pkg::LIM : quo_q[STEPS];

endmodule

@@ rtl/lj_pair_force_kernel.sv @@
// Lennard-Jones shifted-force pair kernel. Takes one candidate pair per clock and returns
// acceleration deltas for atom i and its partner in Q16.16, with a status in m_axis_tuser.
// Every pair runs the same pipeline from acceptance to the result becoming visible; its
// depth is set by the four 64-step dividers, one quotient bit per step (1/r2, sigma2/r2
// and the two cutoff terms), followed by the chain of three-stage multipliers.
// Sustained rate is one pair per cycle; a two-entry output buffer keeps taking pairs while
// one result waits, and the whole pipeline holds only when that buffer is full and not read.
// cutoff_radius must be written through the cfg channel only while the kernel is idle; not enforced.
// Depends on ljpf_pkg, ljpf_delay, ljpf_qmul, ljpf_qdiv and lj_pair_force_kernel_macros.svh.
`include "lj_pair_force_kernel_macros.svh"

module lj_pair_force_kernel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // delta_x, delta_y, delta_z, pair_epsilon, pair_sigma, inv_mass_self, inv_mass_partner,
  // self_index, partner_index, zero pad
  input  logic [ljpf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // partner_ghost
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // accel_self_x, accel_self_y, accel_self_z, accel_partner_x, accel_partner_y,
  // accel_partner_z
  output logic [ljpf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // pair_status
  output logic [2:0]                         m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [30:0]                        cfg_data_i
);

  localparam int unsigned QW = ljpf_pkg::WORD_W;

  function automatic logic [QW:0] scale4(ljpf_pkg::qword_t a);
    return (a > ljpf_pkg::LIM_DIV4) ? {1'b1, ljpf_pkg::LIM} : {1'b0, a << 2};
  endfunction

  function automatic logic [QW:0] scale6(ljpf_pkg::qword_t a);
    return (a > ljpf_pkg::LIM_DIV6) ? {1'b1, ljpf_pkg::LIM} : {1'b0, (a << 2) + (a << 1)};
  endfunction

  function automatic logic [QW:0] scale12(ljpf_pkg::qword_t a);
    return (a > ljpf_pkg::LIM_DIV12) ? {1'b1, ljpf_pkg::LIM} : {1'b0, (a << 3) + (a << 2)};
  endfunction

  function automatic logic [QW:0] clampq(ljpf_pkg::qword_t a);
    return (a > ljpf_pkg::LIM) ? {1'b1, ljpf_pkg::LIM} : {1'b0, a};
  endfunction

  // {sat, 32-bit two's complement value}
  function automatic logic [32:0] to_out(ljpf_pkg::qword_t mag, logic neg);
    logic             over;
    ljpf_pkg::qword_t m;
    logic [31:0]      v;
    if (!neg) begin
      over = mag > ljpf_pkg::POS_MAX;
      m    = over ? ljpf_pkg::POS_MAX : mag;
      v    = m[31:0];
    end else begin
      over = mag > ljpf_pkg::NEG_MAX;
      m    = over ? ljpf_pkg::NEG_MAX : mag;
      v    = ~m[31:0] + 32'd1;
    end
    return {over, v};
  endfunction

  logic        en;
  logic [30:0] cutoff_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= ljpf_pkg::CUTOFF_RESET;
    end else if (cfg_valid_i) begin
      cutoff_q <= cfg_data_i;
    end
  end

  // input unpack
  logic [2:0][31:0] raw;
  logic [2:0][31:0] mag_in;
  logic [11:0]      self_idx, part_idx;
  ljpf_pkg::sb_t    sb1_d, sb1_q, sb2_q, sb3_q, sb4_d, sb4_q;
  logic [30:0]      sigma1_q;

  assign raw[0]   = s_axis_tdata[31:0];
  assign raw[1]   = s_axis_tdata[63:32];
  assign raw[2]   = s_axis_tdata[95:64];
  assign self_idx = s_axis_tdata[231:220];
  assign part_idx = s_axis_tdata[243:232];

  always_comb begin
    for (int unsigned a = 0; a < 3; a++) begin
      mag_in[a] = raw[a][31] ? (~raw[a] + 32'd1) : raw[a];
    end
    sb1_d.valid = s_axis_tvalid;
    sb1_d.skip  = !s_axis_tuser[0] && (self_idx >= part_idx);
    sb1_d.code  = ljpf_pkg::ST_APPLIED;
    sb1_d.mag   = mag_in;
    sb1_d.dneg  = {raw[2][31], raw[1][31], raw[0][31]};
    sb1_d.eps   = s_axis_tdata[126:96];
    sb1_d.ims   = s_axis_tdata[188:158];
    sb1_d.imp   = s_axis_tdata[219:189];
    sb1_d.ghost = s_axis_tuser[0];
  end

  // squares and distance
  ljpf_pkg::qword_t sq_q [3];
  ljpf_pkg::qword_t s2_q, rc2_q, r2_q, s2_3_q, rc2_3_q;

  always_comb begin
    sb4_d = sb3_q;
    if (sb3_q.skip) begin
      sb4_d.code = ljpf_pkg::ST_ORDER_SKIP;
    end else if (r2_q > rc2_3_q) begin
      sb4_d.code = ljpf_pkg::ST_BEYOND;
    end else if (r2_q == '0) begin
      sb4_d.code = ljpf_pkg::ST_ZERO_DIST;
    end else begin
      sb4_d.code = ljpf_pkg::ST_APPLIED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb1_q <= '0;
      sb2_q <= '0;
      sb3_q <= '0;
      sb4_q <= '0;
    end else if (en) begin
      sb1_q <= sb1_d;
      sb2_q <= sb1_q;
      sb3_q <= sb2_q;
      sb4_q <= sb4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sigma1_q <= s_axis_tdata[157:127];
      for (int unsigned a = 0; a < 3; a++) begin
        sq_q[a] <= sb1_q.mag[a] * sb1_q.mag[a];
      end
      s2_q    <= sigma1_q * sigma1_q;
      rc2_q   <= cutoff_q * cutoff_q;
      r2_q    <= sq_q[0] + sq_q[1] + sq_q[2];
      s2_3_q  <= s2_q;
      rc2_3_q <= rc2_q;
    end
  end

  // dividers
  ljpf_pkg::qword_t ir2, rho2, irc2, rhoc2;
  logic             ir2_sat, rho2_sat, irc2_sat, rhoc2_sat;
  ljpf_pkg::sb_t    sb_d0, sb15, sb19, sb22, sb25;

  ljpf_qdiv u_div_ir2 (
    .clk_i, .en_i(en), .a_i(ljpf_pkg::QONE_SQ), .b_i(r2_q), .q_o(ir2), .sat_o(ir2_sat)
  );
  ljpf_qdiv u_div_rho2 (
    .clk_i, .en_i(en), .a_i(s2_3_q), .b_i(r2_q), .q_o(rho2), .sat_o(rho2_sat)
  );
  ljpf_qdiv u_div_irc2 (
    .clk_i, .en_i(en), .a_i(ljpf_pkg::QONE_SQ), .b_i(rc2_3_q), .q_o(irc2), .sat_o(irc2_sat)
  );
  ljpf_qdiv u_div_rhoc2 (
    .clk_i, .en_i(en), .a_i(s2_3_q), .b_i(rc2_3_q), .q_o(rhoc2), .sat_o(rhoc2_sat)
  );

  ljpf_delay #(.WIDTH($bits(ljpf_pkg::sb_t)), .DEPTH(ljpf_pkg::QDIV_LAT - 1)) u_sb_div (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb4_q), .q_o(sb_d0)
  );

  // powers of rho
  ljpf_pkg::qword_t rho4, rhoc4, rho2_d3, rhoc2_d3, rho6, rhoc6, rho12, rhoc12;
  ljpf_pkg::qword_t ir2_d6, irc2_d6, ir2_d9, irc2_d9, t1, t2, t3, t4;
  logic             rho4_sat, rhoc4_sat, rho6_sat, rhoc6_sat, rho12_sat, rhoc12_sat;
  logic             t1_sat, t2_sat, t3_sat, t4_sat;
  logic [QW:0]      t1_d3, t4_d3;

  ljpf_qmul u_rho4 (
    .clk_i, .en_i(en), .a_i(rho2), .b_i(rho2),
    .sat_i(ir2_sat | rho2_sat | irc2_sat | rhoc2_sat), .p_o(rho4), .sat_o(rho4_sat)
  );
  ljpf_qmul u_rhoc4 (
    .clk_i, .en_i(en), .a_i(rhoc2), .b_i(rhoc2), .sat_i(1'b0), .p_o(rhoc4), .sat_o(rhoc4_sat)
  );
  ljpf_delay #(.WIDTH(QW), .DEPTH(ljpf_pkg::QMUL_LAT)) u_rho2_d (
    .clk_i, .rst_ni, .en_i(en), .d_i(rho2), .q_o(rho2_d3)
  );
  ljpf_delay #(.WIDTH(QW), .DEPTH(ljpf_pkg::QMUL_LAT)) u_rhoc2_d (
    .clk_i, .rst_ni, .en_i(en), .d_i(rhoc2), .q_o(rhoc2_d3)
  );
  ljpf_qmul u_rho6 (
    .clk_i, .en_i(en), .a_i(rho4), .b_i(rho2_d3), .sat_i(rho4_sat),
    .p_o(rho6), .sat_o(rho6_sat)
  );
  ljpf_qmul u_rhoc6 (
    .clk_i, .en_i(en), .a_i(rhoc4), .b_i(rhoc2_d3), .sat_i(rhoc4_sat),
    .p_o(rhoc6), .sat_o(rhoc6_sat)
  );
  ljpf_delay #(.WIDTH(QW), .DEPTH(2 * ljpf_pkg::QMUL_LAT)) u_ir2_d6 (
    .clk_i, .rst_ni, .en_i(en), .d_i(ir2), .q_o(ir2_d6)
  );
  ljpf_delay #(.WIDTH(QW), .DEPTH(2 * ljpf_pkg::QMUL_LAT)) u_irc2_d6 (
    .clk_i, .rst_ni, .en_i(en), .d_i(irc2), .q_o(irc2_d6)
  );
  ljpf_qmul u_rho12 (
    .clk_i, .en_i(en), .a_i(rho6), .b_i(rho6), .sat_i(rho6_sat),
    .p_o(rho12), .sat_o(rho12_sat)
  );
  ljpf_qmul u_rhoc12 (
    .clk_i, .en_i(en), .a_i(rhoc6), .b_i(rhoc6), .sat_i(rhoc6_sat),
    .p_o(rhoc12), .sat_o(rhoc12_sat)
  );
  ljpf_qmul u_t1 (
    .clk_i, .en_i(en), .a_i(rho6), .b_i(ir2_d6), .sat_i(1'b0), .p_o(t1), .sat_o(t1_sat)
  );
  ljpf_qmul u_t4 (
    .clk_i, .en_i(en), .a_i(rhoc6), .b_i(irc2_d6), .sat_i(1'b0), .p_o(t4), .sat_o(t4_sat)
  );
  ljpf_delay #(.WIDTH(QW), .DEPTH(ljpf_pkg::QMUL_LAT)) u_ir2_d9 (
    .clk_i, .rst_ni, .en_i(en), .d_i(ir2_d6), .q_o(ir2_d9)
  );
  ljpf_delay #(.WIDTH(QW), .DEPTH(ljpf_pkg::QMUL_LAT)) u_irc2_d9 (
    .clk_i, .rst_ni, .en_i(en), .d_i(irc2_d6), .q_o(irc2_d9)
  );
  ljpf_qmul u_t3 (
    .clk_i, .en_i(en), .a_i(rho12), .b_i(ir2_d9), .sat_i(rho12_sat), .p_o(t3), .sat_o(t3_sat)
  );
  ljpf_qmul u_t2 (
    .clk_i, .en_i(en), .a_i(rhoc12), .b_i(irc2_d9), .sat_i(rhoc12_sat),
    .p_o(t2), .sat_o(t2_sat)
  );
  ljpf_delay #(.WIDTH(QW + 1), .DEPTH(ljpf_pkg::QMUL_LAT)) u_t1_d (
    .clk_i, .rst_ni, .en_i(en), .d_i({t1_sat, t1}), .q_o(t1_d3)
  );
  ljpf_delay #(.WIDTH(QW + 1), .DEPTH(ljpf_pkg::QMUL_LAT)) u_t4_d (
    .clk_i, .rst_ni, .en_i(en), .d_i({t4_sat, t4}), .q_o(t4_d3)
  );

  // bracket: scale, sum, difference
  logic [QW:0]      sc6a, sc12a, sc12b, sc6b, pos_c, neg_c, k4_c;
  ljpf_pkg::qword_t sc6a_q, sc12a_q, sc12b_q, sc6b_q, pos_q, neg_q, kmag_q, kprod, k4_q;
  logic             sat_p1_q, sat_p2_q, sat_p3_q, sat_p4_q, kneg_q, kprod_sat, kneg_d;

  assign sc6a  = scale6(t1_d3[QW-1:0]);
  assign sc12a = scale12(t2);
  assign sc12b = scale12(t3);
  assign sc6b  = scale6(t4_d3[QW-1:0]);
  assign pos_c = clampq(sc6a_q + sc12a_q);
  assign neg_c = clampq(sc12b_q + sc6b_q);
  assign k4_c  = scale4(kprod);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc6a_q   <= sc6a[QW-1:0];
      sc12a_q  <= sc12a[QW-1:0];
      sc12b_q  <= sc12b[QW-1:0];
      sc6b_q   <= sc6b[QW-1:0];
      sat_p1_q <= t1_d3[QW] | t4_d3[QW] | t2_sat | t3_sat
                | sc6a[QW] | sc12a[QW] | sc12b[QW] | sc6b[QW];
      pos_q    <= pos_c[QW-1:0];
      neg_q    <= neg_c[QW-1:0];
      sat_p2_q <= sat_p1_q | pos_c[QW] | neg_c[QW];
      kneg_q   <= neg_q > pos_q;
      kmag_q   <= (neg_q > pos_q) ? neg_q - pos_q : pos_q - neg_q;
      sat_p3_q <= sat_p2_q;
      k4_q     <= k4_c[QW-1:0];
      sat_p4_q <= kprod_sat | k4_c[QW];
    end
  end

  ljpf_delay #(.WIDTH($bits(ljpf_pkg::sb_t)), .DEPTH(15)) u_sb15 (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb_d0), .q_o(sb15)
  );

  ljpf_qmul u_keps (
    .clk_i, .en_i(en), .a_i(QW'(sb15.eps)), .b_i(kmag_q), .sat_i(sat_p3_q),
    .p_o(kprod), .sat_o(kprod_sat)
  );

  ljpf_delay #(.WIDTH($bits(ljpf_pkg::sb_t)), .DEPTH(ljpf_pkg::QMUL_LAT + 1)) u_sb19 (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb15), .q_o(sb19)
  );
  ljpf_delay #(.WIDTH(1), .DEPTH(2 * ljpf_pkg::QMUL_LAT + 1)) u_kneg_d (
    .clk_i, .rst_ni, .en_i(en), .d_i(kneg_q), .q_o(kneg_d)
  );
  ljpf_delay #(.WIDTH($bits(ljpf_pkg::sb_t)), .DEPTH(ljpf_pkg::QMUL_LAT)) u_sb22 (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb19), .q_o(sb22)
  );
  ljpf_delay #(.WIDTH($bits(ljpf_pkg::sb_t)), .DEPTH(ljpf_pkg::QMUL_LAT)) u_sb25 (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb22), .q_o(sb25)
  );

  // per-axis force and acceleration
  ljpf_pkg::qword_t f    [3];
  ljpf_pkg::qword_t acc_s [3];
  ljpf_pkg::qword_t acc_p [3];
  logic [2:0]       f_sat, s_sat, p_sat, fneg, fneg_d;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    ljpf_qmul u_force (
      .clk_i, .en_i(en), .a_i(k4_q), .b_i(QW'(sb19.mag[g])),
      .sat_i((g == 0) ? sat_p4_q : 1'b0), .p_o(f[g]), .sat_o(f_sat[g])
    );
    assign fneg[g] = (kneg_d != sb22.dneg[g]) && (f[g] != '0);
    ljpf_qmul u_self (
      .clk_i, .en_i(en), .a_i(f[g]), .b_i(QW'(sb22.ims)), .sat_i(f_sat[g]),
      .p_o(acc_s[g]), .sat_o(s_sat[g])
    );
    ljpf_qmul u_partner (
      .clk_i, .en_i(en), .a_i(f[g]), .b_i(QW'(sb22.imp)), .sat_i(1'b0),
      .p_o(acc_p[g]), .sat_o(p_sat[g])
    );
  end

  ljpf_delay #(.WIDTH(3), .DEPTH(ljpf_pkg::QMUL_LAT)) u_fneg_d (
    .clk_i, .rst_ni, .en_i(en), .d_i(fneg), .q_o(fneg_d)
  );

  // output formatting
  ljpf_pkg::out_t res;
  logic [2:0][32:0] so, po;
  logic             any_sat;

  always_comb begin
    for (int unsigned a = 0; a < 3; a++) begin
      so[a] = to_out(acc_s[a], fneg_d[a]);
      po[a] = to_out(acc_p[a], !fneg_d[a]);
    end
    any_sat = (|s_sat) | so[0][32] | so[1][32] | so[2][32]
            | (!sb25.ghost & ((|p_sat) | po[0][32] | po[1][32] | po[2][32]));
    res = '0;
    if (sb25.code != ljpf_pkg::ST_APPLIED) begin
      res.status = sb25.code;
    end else begin
      res.status = any_sat ? ljpf_pkg::ST_SATURATED : ljpf_pkg::ST_APPLIED;
      for (int unsigned a = 0; a < 3; a++) begin
        res.accel[a] = so[a][31:0];
        if (!sb25.ghost) begin
          res.accel[a+3] = po[a][31:0];
        end
      end
    end
  end

  // two-entry output buffer
  ljpf_pkg::out_t slot_q [2];
  logic [1:0]     cnt_q;
  logic           rd_q, wr_q, push, pop;
  logic           reject_code;

  assign en            = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;
  assign push          = en && sb25.valid;
  assign pop           = m_axis_tready && (cnt_q != 2'd0);
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = slot_q[rd_q].accel;
  assign m_axis_tuser  = slot_q[rd_q].status;
  assign reject_code   = (m_axis_tuser == ljpf_pkg::ST_BEYOND)
                      || (m_axis_tuser == ljpf_pkg::ST_ORDER_SKIP)
                      || (m_axis_tuser == ljpf_pkg::ST_ZERO_DIST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= res;
    end
  end

  `LJPF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3)
  `LJPF_ASSERT_IMP(a_full_holds_input, (cnt_q == 2'd2) && !m_axis_tready, !s_axis_tready)
  `LJPF_ASSERT_NXT(a_push_counts, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
  `LJPF_ASSERT_IMP(a_reject_zero, m_axis_tvalid && reject_code, m_axis_tdata == '0)

endmodule

@@ test/lj_pair_force_kernel_tb.sv @@
// self-checking testbench for the lennard-jones pair force kernel
// drives pair transactions and cutoff writes, predicts each result in q16.16 and compares
// depends on ljpf_pkg and lj_pair_force_kernel
`timescale 1ns / 1ps

module lj_pair_force_kernel_tb;

  localparam longint unsigned QLIM = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [31:0] dx, dy, dz;
    logic [30:0] eps, sigma, ims, imp;
    logic [11:0] self_idx, part_idx;
    logic        ghost;
  } pair_t;

  typedef struct packed {
    ljpf_pkg::status_e status;
    logic [5:0][31:0]  accel;
  } accel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ljpf_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ljpf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [30:0] cfg_data_i = '0;

  lj_pair_force_kernel dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  logic [30:0] cutoff_q = ljpf_pkg::CUTOFF_RESET;
  accel_t accel_expected_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  longint unsigned cycle_cnt = 0;

  // q16.16 helpers mirroring the kernel arithmetic
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b,
                                             ref bit sat);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >> ljpf_pkg::FRAC_BITS;
    if (p > 128'(QLIM)) begin
      sat = 1'b1;
      return QLIM;
    end
    return p[63:0];
  endfunction

  function automatic longint unsigned fx_div(longint unsigned a, longint unsigned b,
                                             ref bit sat);
    logic [127:0] q;
    if (b == 0 || (a >> (64 - ljpf_pkg::FRAC_BITS)) >= b) begin
      sat = 1'b1;
      return QLIM;
    end
    q = (128'(a) << ljpf_pkg::FRAC_BITS) / 128'(b);
    if (q > 128'(QLIM)) begin
      sat = 1'b1;
      return QLIM;
    end
    return q[63:0];
  endfunction

  function automatic longint unsigned fx_scale(longint unsigned a, longint unsigned k,
                                               ref bit sat);
    if (a > QLIM / k) begin
      sat = 1'b1;
      return QLIM;
    end
    return a * k;
  endfunction

  function automatic longint unsigned fx_clamp(longint unsigned v, ref bit sat);
    if (v > QLIM) begin
      sat = 1'b1;
      return QLIM;
    end
    return v;
  endfunction

  function automatic logic [31:0] fx_out(longint unsigned m, bit neg, ref bit sat);
    if (!neg) begin
      if (m > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        m = 64'h7FFF_FFFF;
      end
      return m[31:0];
    end
    if (m > 64'h8000_0000) begin
      sat = 1'b1;
      m = 64'h8000_0000;
    end
    return 32'(0 - m);
  endfunction

  function automatic accel_t predict_accel(pair_t p, logic [30:0] rc);
    accel_t r;
    longint unsigned mag[3], r2, rc2, s2, ir2, rho2, rho6, rho12, irc2, rhoc2, rhoc6;
    longint unsigned rhoc12, pos, neg, k, f;
    logic [31:0] d[3];
    bit dneg[3], kneg, fneg, sat;
    sat = 1'b0;
    r = '0;
    d[0] = p.dx;
    d[1] = p.dy;
    d[2] = p.dz;
    for (int a = 0; a < 3; a++) begin
      dneg[a] = d[a][31];
      mag[a] = dneg[a] ? (64'd1 << 32) - 64'(d[a]) : 64'(d[a]);
    end
    if (!p.ghost && !(p.self_idx < p.part_idx)) begin
      r.status = ljpf_pkg::ST_ORDER_SKIP;
      return r;
    end
    r2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    rc2 = 64'(rc) * 64'(rc);
    if (r2 > rc2) begin
      r.status = ljpf_pkg::ST_BEYOND;
      return r;
    end
    if (r2 == 0) begin
      r.status = ljpf_pkg::ST_ZERO_DIST;
      return r;
    end
    s2 = 64'(p.sigma) * 64'(p.sigma);
    ir2 = fx_div(ljpf_pkg::QONE_SQ, r2, sat);
    rho2 = fx_div(s2, r2, sat);
    rho6 = fx_mul(fx_mul(rho2, rho2, sat), rho2, sat);
    rho12 = fx_mul(rho6, rho6, sat);
    irc2 = fx_div(ljpf_pkg::QONE_SQ, rc2, sat);
    rhoc2 = fx_div(s2, rc2, sat);
    rhoc6 = fx_mul(fx_mul(rhoc2, rhoc2, sat), rhoc2, sat);
    rhoc12 = fx_mul(rhoc6, rhoc6, sat);
    pos = fx_scale(fx_mul(rho6, ir2, sat), 6, sat);
    pos = fx_clamp(pos + fx_scale(fx_mul(rhoc12, irc2, sat), 12, sat), sat);
    neg = fx_scale(fx_mul(rho12, ir2, sat), 12, sat);
    neg = fx_clamp(neg + fx_scale(fx_mul(rhoc6, irc2, sat), 6, sat), sat);
    kneg = neg > pos;
    k = kneg ? neg - pos : pos - neg;
    k = fx_scale(fx_mul(64'(p.eps), k, sat), 4, sat);
    for (int a = 0; a < 3; a++) begin
      f = fx_mul(k, mag[a], sat);
      fneg = (kneg != dneg[a]) && f != 0;
      r.accel[a] = fx_out(fx_mul(f, 64'(p.ims), sat), fneg, sat);
      if (!p.ghost) r.accel[3 + a] = fx_out(fx_mul(f, 64'(p.imp), sat), !fneg, sat);
    end
    r.status = sat ? ljpf_pkg::ST_SATURATED : ljpf_pkg::ST_APPLIED;
    return r;
  endfunction

  task automatic send_pair(pair_t p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {24'd0, p.part_idx, p.self_idx, p.imp, p.ims, p.sigma, p.eps,
                     p.dz, p.dy, p.dx};
    s_axis_tuser <= p.ghost;
    do @(posedge clk_i); while (!s_axis_tready);
    accel_expected_q.push_back(predict_accel(p, cutoff_q));
    sent_cnt++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (accel_expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_cutoff(logic [30:0] rc);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= rc;
    do @(posedge clk_i); while (!cfg_ready_o);
    cutoff_q = rc;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pair_t rand_pair(bit near);
    pair_t p;
    p.dx = $urandom;
    p.dy = $urandom;
    p.dz = $urandom;
    if (near) begin
      p.dx = 32'($signed($urandom_range(262144)) - 131072);
      p.dy = 32'($signed($urandom_range(262144)) - 131072);
      p.dz = 32'($signed($urandom_range(262144)) - 131072);
    end
    p.eps = near ? 31'($urandom_range(131072)) : 31'($urandom);
    p.sigma = near ? 31'($urandom_range(32768, 98304)) : 31'($urandom);
    p.ims = near ? 31'($urandom_range(262144)) : 31'($urandom);
    p.imp = near ? 31'($urandom_range(262144)) : 31'($urandom);
    p.self_idx = 12'($urandom);
    p.part_idx = 12'($urandom);
    p.ghost = 1'($urandom);
    if (near && !p.ghost && p.part_idx <= p.self_idx && $urandom_range(9) != 0) begin
      p.self_idx = 12'($urandom_range(4094));
      p.part_idx = 12'($urandom_range(4095, p.self_idx + 1));
    end
    return p;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    accel_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = ljpf_pkg::status_e'(m_axis_tuser);
      got.accel = m_axis_tdata;
      checked_cnt++;
      if (accel_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = accel_expected_q.pop_front();
        for (int f = 0; f < 7; f++) begin
          if ((f < 6 && got.accel[f] !== exp_r.accel[f]) ||
              (f == 6 && got.status !== exp_r.status)) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("field %0d mismatch: expected %h actual %h", f,
                       f < 6 ? exp_r.accel[f] : 32'(exp_r.status),
                       f < 6 ? got.accel[f] : 32'(got.status));
          end
        end
      end
    end
  end

  task automatic test_directed();
    pair_t p;
    p = '0;
    p.eps = 31'h10000;
    p.sigma = 31'h10000;
    p.ims = 31'h10000;
    p.imp = 31'h10000;
    p.self_idx = 12'd1;
    p.part_idx = 12'd2;
    p.dx = 32'h0001_0000;
    send_pair(p);
    p.dx = 32'hFFFF_0000;
    p.dy = 32'h0000_8000;
    send_pair(p);
    p.ghost = 1'b1;
    send_pair(p);
    p.ghost = 1'b0;
    p.part_idx = 12'd1;
    send_pair(p);
    p.self_idx = 12'd4095;
    p.part_idx = 12'd0;
    send_pair(p);
    p.ghost = 1'b1;
    send_pair(p);
    p = '0;
    p.self_idx = 12'd0;
    p.part_idx = 12'd4095;
    send_pair(p);
    p.dx = 32'h8000_0000;
    p.dy = 32'h7FFF_FFFF;
    p.dz = 32'h8000_0000;
    send_pair(p);
    p.dx = 32'h0000_0001;
    p.dy = 32'h0;
    p.dz = 32'h0;
    p.eps = 31'h7FFF_FFFF;
    p.sigma = 31'h7FFF_FFFF;
    p.ims = 31'h7FFF_FFFF;
    p.imp = 31'h7FFF_FFFF;
    send_pair(p);
    p.dx = 32'h0002_0000;
    p.sigma = 31'h0001_0000;
    p.eps = 31'h0000_0001;
    send_pair(p);
    p.dz = 32'hFFFE_8000;
    p.dx = 32'h0;
    p.ghost = 1'b1;
    send_pair(p);
    p.dz = 32'h0002_8000;
    send_pair(p);
    p.dz = 32'h0002_8001;
    send_pair(p);
  endtask

  task automatic test_cutoff_extremes();
    pair_t p;
    p = '0;
    p.self_idx = 12'd3;
    p.part_idx = 12'd9;
    p.eps = 31'h10000;
    p.sigma = 31'h10000;
    p.ims = 31'h10000;
    p.imp = 31'h10000;
    write_cutoff(31'd0);
    send_pair(p);
    p.dy = 32'h1;
    send_pair(p);
    write_cutoff(31'h7FFF_FFFF);
    p.dx = 32'h8000_0000;
    p.dy = 32'h8000_0000;
    p.dz = 32'h8000_0000;
    send_pair(p);
    p.dx = 32'h0000_4000;
    p.dy = 32'h0;
    p.dz = 32'h0;
    send_pair(p);
    write_cutoff(31'd1);
    send_pair(p);
  endtask

  task automatic test_random(int unsigned n, logic [30:0] rc);
    write_cutoff(rc);
    for (int unsigned i = 0; i < n; i++) send_pair(rand_pair($urandom_range(9) < 8));
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int unsigned i = 0; i < 120; i++) send_pair(rand_pair(1'b1));
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10;
    recv_idle_pct = 63;
    test_directed();
    test_cutoff_extremes();
    test_random(300, ljpf_pkg::CUTOFF_RESET);
    send_idle_pct = 63;
    recv_idle_pct = 10;
    test_random(250, 31'h0001_8000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250, 31'h0004_0000);
    test_backpressure();
    drain_results();
    $display("covered %0d pairs and %0d results over six cutoff settings,", sent_cnt,
             checked_cnt);
    $display("skip, cutoff, zero distance, saturation, ghost cases and a long output stall");
    if (mismatch_cnt == 0 && accel_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, accel_expected_q.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ljpf_pkg.sv
rtl/ljpf_delay.sv
rtl/ljpf_qmul.sv
rtl/ljpf_qdiv.sv
rtl/lj_pair_force_kernel.sv
test/lj_pair_force_kernel_tb.sv
